[hw/rtl/gpr_pkg.sv]
// Shared types, register offsets and reset values for the GPIO port register block.
`timescale 1ns / 1ps
`default_nettype none

package gpr_pkg;

  localparam int DEFAULT_PORT_INDEX = 0;

  localparam int ADDR_W = 10;
  localparam int DATA_W = 32;
  localparam int PINS   = 16;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  localparam logic [ADDR_W-1:0] OFF_MODE  = 10'h000;
  localparam logic [ADDR_W-1:0] OFF_OTYPE = 10'h004;
  localparam logic [ADDR_W-1:0] OFF_SPEED = 10'h008;
  localparam logic [ADDR_W-1:0] OFF_PULL  = 10'h00C;
  localparam logic [ADDR_W-1:0] OFF_IDR   = 10'h010;
  localparam logic [ADDR_W-1:0] OFF_ODR   = 10'h014;
  localparam logic [ADDR_W-1:0] OFF_BSRR  = 10'h018;
  localparam logic [ADDR_W-1:0] OFF_LOCK  = 10'h01C;
  localparam logic [ADDR_W-1:0] OFF_AFL   = 10'h020;
  localparam logic [ADDR_W-1:0] OFF_AFH   = 10'h024;
  localparam logic [ADDR_W-1:0] OFF_BRR   = 10'h028;

  typedef struct packed {
    logic [1:0]        size;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] addr;
    logic              cmd;
  } req_t;

  typedef struct packed {
    logic              err;
    logic [PINS-1:0]   pins;
    logic [DATA_W-1:0] rdata;
  } resp_t;

  function automatic logic [DATA_W-1:0] mode_reset(int port);
    if (port == 0) return 32'hA800_0000;
    else if (port == 1) return 32'h0000_0280;
    else return '0;
  endfunction

  function automatic logic [DATA_W-1:0] speed_reset(int port);
    if (port == 0) return 32'h0C00_0000;
    else if (port == 1) return 32'h0000_00C0;
    else return '0;
  endfunction

  function automatic logic [DATA_W-1:0] pull_reset(int port);
    if (port == 0) return 32'h6400_0000;
    else if (port == 1) return 32'h0000_0100;
    else return '0;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gpr_stage.sv]
// Register slice that holds one beat and passes it on under a valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

module gpr_stage #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WIDTH-1:0]      out_data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gpr_core.sv]
// Port registers with the read decode, write merge and set/reset pin logic.
`timescale 1ns / 1ps
`default_nettype none

module gpr_core
  import gpr_pkg::*;
#(
  parameter int PORT_INDEX = DEFAULT_PORT_INDEX
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  wire req_t req_i,
  output resp_t     resp_o
);

  logic [DATA_W-1:0] mode_q, mode_d;
  logic [PINS-1:0]   otype_q, otype_d;
  logic [DATA_W-1:0] speed_q, speed_d;
  logic [DATA_W-1:0] pull_q, pull_d;
  logic [PINS-1:0]   odr_q, odr_d;
  logic [DATA_W-1:0] afl_q, afl_d;
  logic [DATA_W-1:0] afh_q, afh_d;
  logic [PINS-1:0]   drive_q, drive_d;

  logic [DATA_W-1:0] rd_val;
  logic              rd_known;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] cur_val;
  logic [4:0]        shift;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] wr_val;
  logic [PINS-1:0]   set_bits, clr_bits, up, down;
  logic              err;

  always_comb begin
    rd_known = 1'b1;
    unique case (req_i.addr)
      OFF_MODE:  rd_val = mode_q;
      OFF_OTYPE: rd_val = {16'h0, otype_q};
      OFF_SPEED: rd_val = speed_q;
      OFF_PULL:  rd_val = pull_q;
      OFF_IDR:   rd_val = '0;
      OFF_ODR:   rd_val = {16'h0, odr_q};
      OFF_BSRR:  rd_val = '0;
      OFF_LOCK:  rd_val = '0;
      OFF_AFL:   rd_val = afl_q;
      OFF_AFH:   rd_val = afh_q;
      default: begin
        rd_val   = '0;
        rd_known = 1'b0;
      end
    endcase
  end

  assign wr_addr = (req_i.size == SIZE_WORD) ? req_i.addr : {req_i.addr[ADDR_W-1:2], 2'b00};
  assign shift   = {req_i.addr[1:0], 3'b000};
  assign mask    = (req_i.size == SIZE_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF;

  always_comb begin
    unique case (wr_addr)
      OFF_MODE:  cur_val = mode_q;
      OFF_OTYPE: cur_val = {16'h0, otype_q};
      OFF_SPEED: cur_val = speed_q;
      OFF_PULL:  cur_val = pull_q;
      OFF_ODR:   cur_val = {16'h0, odr_q};
      OFF_AFL:   cur_val = afl_q;
      OFF_AFH:   cur_val = afh_q;
      default:   cur_val = '0;
    endcase
  end

  assign wr_val = (req_i.size == SIZE_WORD) ? req_i.wdata
                : ((cur_val & ~(mask << shift)) | ((req_i.wdata & mask) << shift));

  assign set_bits = wr_val[15:0];
  assign clr_bits = wr_val[31:16];
  assign up       = set_bits & ~clr_bits;
  assign down     = clr_bits & ~set_bits;

  always_comb begin
    mode_d  = mode_q;
    otype_d = otype_q;
    speed_d = speed_q;
    pull_d  = pull_q;
    odr_d   = odr_q;
    afl_d   = afl_q;
    afh_d   = afh_q;
    drive_d = drive_q;
    err     = 1'b0;
    if (req_i.cmd == CMD_READ) begin
      err = !rd_known || (req_i.size != SIZE_WORD);
    end else if (req_i.size == SIZE_BAD) begin
      err = 1'b1;
    end else begin
      unique case (wr_addr)
        OFF_MODE:  mode_d  = wr_val;
        OFF_OTYPE: otype_d = wr_val[15:0];
        OFF_SPEED: speed_d = wr_val;
        OFF_PULL:  pull_d  = wr_val;
        OFF_ODR:   odr_d   = wr_val[15:0];
        OFF_BSRR: begin
          err     = |(set_bits & clr_bits);
          odr_d   = (odr_q | up) & ~down;
          drive_d = (drive_q | up) & ~down;
        end
        OFF_AFL:   afl_d   = wr_val;
        OFF_AFH:   afh_d   = wr_val;
        OFF_BRR:   drive_d = drive_q & ~wr_val[15:0];
        default:   err     = 1'b1;
      endcase
    end
  end

  assign resp_o.rdata = (req_i.cmd == CMD_READ) ? rd_val : '0;
  assign resp_o.pins  = drive_d;
  assign resp_o.err   = err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mode_reset(PORT_INDEX);
      otype_q <= '0;
      speed_q <= speed_reset(PORT_INDEX);
      pull_q  <= pull_reset(PORT_INDEX);
      odr_q   <= '0;
      afl_q   <= '0;
      afh_q   <= '0;
      drive_q <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      otype_q <= otype_d;
      speed_q <= speed_d;
      pull_q  <= pull_d;
      odr_q   <= odr_d;
      afl_q   <= afl_d;
      afh_q   <= afh_d;
      drive_q <= drive_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gpio_port_register_block.sv]
// Top level of the GPIO port register block with its input and result register slices.
`timescale 1ns / 1ps
`default_nettype none

// Register block of one 16-pin GPIO port. Each input beat is one bus access and yields
// exactly one result beat holding the read data, the driven pin levels after the access
// and an error flag. An access is taken into an input register, then decoded and applied to
// the port registers while its result is captured in the output register, so the block
// accepts one beat per cycle when the output side does not stall, and the result is
// presented from the output register. The rate is set by the read-modify-write of the
// port registers, which is combinational and takes effect on the same edge that
// captures the result.
module gpio_port_register_block
  import gpr_pkg::*;
#(
  parameter int PORT_INDEX = DEFAULT_PORT_INDEX
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // address, write_data, access_size, zero pad
  input  wire logic        s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // read_data, pin_levels
  output logic             m_axis_tuser    // access_error
);

  req_t  in_req, core_req;
  resp_t core_resp, out_resp;
  logic  req_valid, resp_ready;

  assign in_req.cmd   = s_axis_tuser;
  assign in_req.addr  = s_axis_tdata[9:0];
  assign in_req.wdata = s_axis_tdata[41:10];
  assign in_req.size  = s_axis_tdata[43:42];

  gpr_stage #(
    .WIDTH($bits(req_t))
  ) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (in_req),
    .out_valid_o(req_valid),
    .out_ready_i(resp_ready),
    .out_data_o (core_req)
  );

  gpr_core #(
    .PORT_INDEX(PORT_INDEX)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(req_valid && resp_ready),
    .req_i (core_req),
    .resp_o(core_resp)
  );

  gpr_stage #(
    .WIDTH($bits(resp_t))
  ) u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_ready_o (resp_ready),
    .in_data_i  (core_resp),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_resp)
  );

  assign m_axis_tdata = {out_resp.pins, out_resp.rdata};
  assign m_axis_tuser = out_resp.err;

endmodule

`default_nettype wire
